### rtl/core/pt64_pkg.sv
// Shared types and constants for the 64-bit primality tester.
package pt64_pkg;

  localparam int unsigned W = 64;
  localparam int unsigned NumSmall = 25;
  localparam int unsigned NumMr = 7;

  typedef enum logic [2:0] {
    VERD_PRIME   = 3'd0,
    VERD_BELOW2  = 3'd1,
    VERD_SMALL   = 3'd2,
    VERD_FERMAT  = 3'd3,
    VERD_MR      = 3'd4
  } verdict_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIAL,
    ST_TRIAL_WAIT,
    ST_BASE,
    ST_BASE_RED,
    ST_POW_SQ,
    ST_POW_SQ_WAIT,
    ST_POW_MUL,
    ST_POW_MUL_WAIT,
    ST_EVAL,
    ST_MR_SQ,
    ST_MR_SQ_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic start;
    logic busy;
  } mm_ctl_t;

  function automatic logic [6:0] small_prime(input logic [4:0] idx);
    logic [6:0] p;
    case (idx)
      5'd0: p = 7'd2;    5'd1: p = 7'd3;    5'd2: p = 7'd5;    5'd3: p = 7'd7;
      5'd4: p = 7'd11;   5'd5: p = 7'd13;   5'd6: p = 7'd17;   5'd7: p = 7'd19;
      5'd8: p = 7'd23;   5'd9: p = 7'd29;   5'd10: p = 7'd31;  5'd11: p = 7'd37;
      5'd12: p = 7'd41;  5'd13: p = 7'd43;  5'd14: p = 7'd47;  5'd15: p = 7'd53;
      5'd16: p = 7'd59;  5'd17: p = 7'd61;  5'd18: p = 7'd67;  5'd19: p = 7'd71;
      5'd20: p = 7'd73;  5'd21: p = 7'd79;  5'd22: p = 7'd83;  5'd23: p = 7'd89;
      5'd24: p = 7'd97;
      default: p = 7'd2;
    endcase
    return p;
  endfunction

  // Bases 0..1 are Fermat, 2..8 Miller-Rabin.
  function automatic logic [30:0] test_base(input logic [3:0] idx);
    logic [30:0] b;
    case (idx)
      4'd0: b = 31'd2;
      4'd1: b = 31'd3;
      4'd2: b = 31'd2;
      4'd3: b = 31'd325;
      4'd4: b = 31'd9375;
      4'd5: b = 31'd28178;
      4'd6: b = 31'd450775;
      4'd7: b = 31'd9780504;
      4'd8: b = 31'd1795265022;
      default: b = 31'd2;
    endcase
    return b;
  endfunction

endpackage

### rtl/core/pt64_rem.sv
// Bit-serial remainder of a 64-bit value by a 7-bit divisor.
module pt64_rem (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pt64_pkg::mm_ctl_t       ctl_i,
  input  logic [pt64_pkg::W-1:0]  num_i,
  input  logic [6:0]              div_i,
  output logic                    busy_o,
  output logic                    zero_o
);
  logic [pt64_pkg::W-1:0] sh_q, sh_d;
  logic [6:0] r_q, r_d, div_q, div_d;
  logic [6:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [7:0] t;

  always_comb begin
    sh_d = sh_q;
    r_d = r_q;
    div_d = div_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    t = {r_q, sh_q[pt64_pkg::W-1]};
    if (ctl_i.start) begin
      sh_d = num_i;
      r_d = '0;
      div_d = div_i;
      cnt_d = 7'(pt64_pkg::W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d = (t >= {1'b0, div_q}) ? 7'(t - {1'b0, div_q}) : t[6:0];
      sh_d = {sh_q[pt64_pkg::W-2:0], 1'b0};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    r_q <= r_d;
    div_q <= div_d;
  end

  assign busy_o = busy_q;
  assign zero_o = (r_q == 7'd0);

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 7'd0) else $error("rem count lost");
  a_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !ctl_i.start && div_q != 7'd0) |=> r_q < div_q)
    else $error("rem out of range");
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == 7'd1 && !ctl_i.start) |=> !busy_q)
    else $error("rem did not finish");
endmodule

### rtl/core/pt64_mulmod.sv
// Bit-serial modular multiplier: a*b mod m by double and add, one bit of b per cycle.
module pt64_mulmod (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pt64_pkg::mm_ctl_t       ctl_i,
  input  logic [pt64_pkg::W-1:0]  a_i,
  input  logic [pt64_pkg::W-1:0]  b_i,
  input  logic [pt64_pkg::W-1:0]  m_i,
  output logic                    busy_o,
  output logic [pt64_pkg::W-1:0]  r_o
);
  localparam int unsigned W = pt64_pkg::W;
  logic [W-1:0] a_q, a_d, b_q, b_d, m_q, m_d, r_q, r_d;
  logic [6:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [W:0] dbl, add;
  logic [W-1:0] r1;

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    m_d = m_q;
    r_d = r_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    dbl = {r_q, 1'b0};
    r1 = (dbl >= {1'b0, m_q}) ? W'(dbl - {1'b0, m_q}) : dbl[W-1:0];
    add = {1'b0, r1} + {1'b0, a_q};
    if (ctl_i.start) begin
      a_d = a_i;
      b_d = b_i;
      m_d = m_i;
      r_d = '0;
      cnt_d = 7'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[W-1]) begin
        r_d = (add >= {1'b0, m_q}) ? W'(add - {1'b0, m_q}) : add[W-1:0];
      end else begin
        r_d = r1;
      end
      b_d = {b_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    m_q <= m_d;
    r_q <= r_d;
  end

  assign busy_o = busy_q;
  assign r_o = r_q;

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 7'd0) else $error("mulmod count lost");
  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == 7'd1 && !ctl_i.start) |=> !busy_q)
    else $error("mulmod did not finish");
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q && !ctl_i.start) |=> $stable(r_q)) else $error("mulmod result moved");
endmodule

### rtl/core/prime_test_64bit_top.sv
// Top level of the deterministic 64-bit primality tester.
// Each remainder or product is computed bit-serially by its unit; trial
// division runs up to 25 remainders, each of the nine bases one reduction plus 128 products,
// and each Miller-Rabin base up to 62 more squarings.
// One item at a time; the next item is taken once the result has been delivered.
// Reset clears the sequencer and the output valid; no memory needs clearing.
module prime_test_64bit_top #(
  parameter int unsigned TRIAL_PRIMES = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [63:0] number_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic        is_prime_o,
  output logic [2:0]  verdict_o
);
  localparam int unsigned W = pt64_pkg::W;
  localparam int unsigned NTrial = (TRIAL_PRIMES > 25) ? 25 : TRIAL_PRIMES;

  pt64_pkg::state_e st_q, st_d;
  logic [W-1:0] n_q, n_d, nm1_q, nm1_d, x_q, x_d, a_q, a_d, e_q, e_d;
  logic [6:0] ecnt_q, ecnt_d, s_q, s_d, j_q, j_d;
  logic [4:0] pi_q, pi_d;
  logic [3:0] bi_q, bi_d;
  logic [2:0] verd_q, verd_d;
  logic ovalid_q, ovalid_d;

  pt64_pkg::mm_ctl_t mm_ctl, rem_ctl;
  logic [W-1:0] mm_a, mm_b, mm_m, mm_r;
  logic mm_busy, rem_busy, rem_zero;
  logic [6:0] tz;
  logic [W-1:0] dodd;

  pt64_rem u_rem (
    .clk_i, .rst_ni, .ctl_i(rem_ctl), .num_i(n_q),
    .div_i(pt64_pkg::small_prime(pi_q)), .busy_o(rem_busy), .zero_o(rem_zero)
  );

  pt64_mulmod u_mm (
    .clk_i, .rst_ni, .ctl_i(mm_ctl), .a_i(mm_a), .b_i(mm_b), .m_i(mm_m),
    .busy_o(mm_busy), .r_o(mm_r)
  );

  always_comb begin
    tz = '0;
    for (int k = W - 1; k >= 0; k--) begin
      if (nm1_q[k]) tz = 7'(k);
    end
    dodd = nm1_q >> tz;
  end

  always_comb begin
    st_d = st_q;
    n_d = n_q; nm1_d = nm1_q; x_d = x_q; a_d = a_q; e_d = e_q;
    ecnt_d = ecnt_q; s_d = s_q; j_d = j_q; pi_d = pi_q; bi_d = bi_q;
    verd_d = verd_q;
    ovalid_d = ovalid_q;
    case (st_q)
      pt64_pkg::ST_IDLE: begin
        if (valid_i) begin
          n_d = number_i;
          nm1_d = number_i - 64'd1;
          pi_d = '0;
          bi_d = '0;
          if (number_i < 64'd2) begin
            verd_d = pt64_pkg::VERD_BELOW2;
            st_d = pt64_pkg::ST_DONE;
          end else if (NTrial == 0) begin
            st_d = pt64_pkg::ST_BASE;
          end else begin
            st_d = pt64_pkg::ST_TRIAL;
          end
        end
      end
      pt64_pkg::ST_TRIAL: begin
        if (n_q == {57'd0, pt64_pkg::small_prime(pi_q)}) begin
          verd_d = pt64_pkg::VERD_PRIME;
          st_d = pt64_pkg::ST_DONE;
        end else begin
          st_d = pt64_pkg::ST_TRIAL_WAIT;
        end
      end
      pt64_pkg::ST_TRIAL_WAIT: begin
        if (!rem_busy) begin
          if (rem_zero) begin
            verd_d = pt64_pkg::VERD_SMALL;
            st_d = pt64_pkg::ST_DONE;
          end else if (32'(pi_q) == NTrial - 1) begin
            st_d = pt64_pkg::ST_BASE;
          end else begin
            pi_d = pi_q + 5'd1;
            st_d = pt64_pkg::ST_TRIAL;
          end
        end
      end
      pt64_pkg::ST_BASE: begin
        if (bi_q == 4'(2 + pt64_pkg::NumMr)) begin
          verd_d = pt64_pkg::VERD_PRIME;
          st_d = pt64_pkg::ST_DONE;
        end else begin
          s_d = tz;
          st_d = pt64_pkg::ST_BASE_RED;
        end
      end
      pt64_pkg::ST_BASE_RED: begin
        if (!mm_busy) begin
          if (mm_r == '0) begin
            bi_d = bi_q + 4'd1;
            st_d = pt64_pkg::ST_BASE;
          end else begin
            a_d = mm_r;
            x_d = 64'd1;
            e_d = (bi_q < 4'd2) ? nm1_q : dodd;
            ecnt_d = 7'(W);
            st_d = pt64_pkg::ST_POW_MUL;
          end
        end
      end
      pt64_pkg::ST_POW_MUL: begin
        st_d = pt64_pkg::ST_POW_MUL_WAIT;
      end
      pt64_pkg::ST_POW_MUL_WAIT: begin
        if (!mm_busy) begin
          if (e_q[0]) x_d = mm_r;
          st_d = pt64_pkg::ST_POW_SQ;
        end
      end
      pt64_pkg::ST_POW_SQ: begin
        st_d = pt64_pkg::ST_POW_SQ_WAIT;
      end
      pt64_pkg::ST_POW_SQ_WAIT: begin
        if (!mm_busy) begin
          a_d = mm_r;
          e_d = e_q >> 1;
          ecnt_d = ecnt_q - 7'd1;
          st_d = (ecnt_q == 7'd1) ? pt64_pkg::ST_EVAL : pt64_pkg::ST_POW_MUL;
        end
      end
      pt64_pkg::ST_EVAL: begin
        if (bi_q < 4'd2) begin
          if (x_q != 64'd1) begin
            verd_d = pt64_pkg::VERD_FERMAT;
            st_d = pt64_pkg::ST_DONE;
          end else begin
            bi_d = bi_q + 4'd1;
            st_d = pt64_pkg::ST_BASE;
          end
        end else if (x_q == 64'd1 || x_q == nm1_q) begin
          bi_d = bi_q + 4'd1;
          st_d = pt64_pkg::ST_BASE;
        end else begin
          j_d = 7'd1;
          st_d = pt64_pkg::ST_MR_SQ;
        end
      end
      pt64_pkg::ST_MR_SQ: begin
        if (j_q >= s_q) begin
          verd_d = pt64_pkg::VERD_MR;
          st_d = pt64_pkg::ST_DONE;
        end else begin
          st_d = pt64_pkg::ST_MR_SQ_WAIT;
        end
      end
      pt64_pkg::ST_MR_SQ_WAIT: begin
        if (!mm_busy) begin
          x_d = mm_r;
          j_d = j_q + 7'd1;
          if (mm_r == nm1_q) begin
            bi_d = bi_q + 4'd1;
            st_d = pt64_pkg::ST_BASE;
          end else begin
            st_d = pt64_pkg::ST_MR_SQ;
          end
        end
      end
      pt64_pkg::ST_DONE: begin
        ovalid_d = 1'b1;
        if (ovalid_q && ready_i) begin
          ovalid_d = 1'b0;
          st_d = pt64_pkg::ST_IDLE;
        end
      end
      default: st_d = pt64_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rem_ctl = '0;
    mm_ctl = '0;
    mm_a = x_q;
    mm_b = a_q;
    mm_m = n_q;
    rem_ctl.start = (st_q == pt64_pkg::ST_TRIAL) &&
                    (n_q != {57'd0, pt64_pkg::small_prime(pi_q)});
    rem_ctl.busy = rem_busy;
    case (st_q)
      pt64_pkg::ST_BASE: begin
        // base mod n as 1 * base mod n
        mm_a = 64'd1;
        mm_b = {33'd0, pt64_pkg::test_base(bi_q)};
        mm_ctl.start = (bi_q != 4'(2 + pt64_pkg::NumMr)) && (n_q > 64'd1);
      end
      pt64_pkg::ST_POW_MUL: begin
        mm_ctl.start = 1'b1;
      end
      pt64_pkg::ST_POW_SQ: begin
        mm_a = a_q;
        mm_ctl.start = 1'b1;
      end
      pt64_pkg::ST_MR_SQ: begin
        mm_b = x_q;
        mm_ctl.start = (j_q < s_q);
      end
      default: ;
    endcase
    mm_ctl.busy = mm_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= pt64_pkg::ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; nm1_q <= nm1_d; x_q <= x_d; a_q <= a_d; e_q <= e_d;
    ecnt_q <= ecnt_d; s_q <= s_d; j_q <= j_d; pi_q <= pi_d; bi_q <= bi_d;
    verd_q <= verd_d;
  end

  assign ready_o = (st_q == pt64_pkg::ST_IDLE);
  assign valid_o = ovalid_q;
  assign verdict_o = verd_q;
  assign is_prime_o = (verd_q == pt64_pkg::VERD_PRIME);

  a_ovalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> st_q == pt64_pkg::ST_DONE) else $error("result outside done");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> valid_o && $stable(verdict_o)) else $error("result dropped");
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> verdict_o <= pt64_pkg::VERD_MR) else $error("bad verdict");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mm_busy && rem_busy)) else $error("units overlap");
endmodule
